// ===== hdl/pre_pkg.sv =====
// Package for the polyline ribbon extruder: normal format, reset values, widths.
// No dependencies; imported by the top level and by its checker.
package pre_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int NRM_W           = 16;
	localparam int SCALE_W         = 16;
	localparam int TEX_W           = 32;

	typedef logic signed [NRM_W-1:0] nrm_t;

	localparam nrm_t              NRM_ONE   = 16'sd16384;
	localparam logic [SCALE_W-1:0] SCALE_RST = 16'd256;
	localparam logic [TEX_W-1:0]   STR_SAT   = 32'h8000_0000;
	localparam logic [63:0]        LEN_CAP   = 64'h0000_0100_0000_0000;

endpackage

// ===== hdl/polyline_ribbon_extruder.sv =====
// Polyline ribbon extruder: turns streamed polyline points into ribbon vertex pairs.
// The time from an accepted point to its pair is set by the shared bit-serial
// square root (32 steps, twice per pair), the 16-step divider run twice and the normalising
// shifts; when the horizontal direction is zero the second root and the divisions are skipped.
// Throughput: one item at a time; s_tready is low while a pair is computed or waits.
// A point with a second pair (last point) takes two such runs; a first point is only stored.
// Reset (arst_n low, asynchronous): idle, normal +z, twist positive, trail_scale 1.0.
module polyline_ribbon_extruder
	import pre_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// point_x, point_y, point_z from bit 0 up, zero padded to bytes
	input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// left_x, left_y, left_z, right_x, right_y, right_z, center_x, center_y, center_z,
	// tex_v from bit 0 up, zero padded to bytes
	output logic [((9*COORD_WIDTH+32+7)/8)*8-1:0] m_tdata,
	// twist_positive
	output logic                 m_tuser,
	output logic                 m_tlast,
	input  logic                 cfg_we,
	input  logic [SCALE_W-1:0]   cfg_wdata
);

	localparam int CW = COORD_WIDTH;
	localparam int OW = ((9*CW+32+7)/8)*8;
	localparam int MW = (CW > 32) ? CW : 32;
	localparam int SW = ((CW > 18) ? CW : 18) + 1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LD   = 4'd1;
	localparam logic [3:0] ST_LSH  = 4'd2;
	localparam logic [3:0] ST_LSQ  = 4'd3;
	localparam logic [3:0] ST_LRT  = 4'd4;
	localparam logic [3:0] ST_STR  = 4'd5;
	localparam logic [3:0] ST_ACC  = 4'd6;
	localparam logic [3:0] ST_NLD  = 4'd7;
	localparam logic [3:0] ST_NSH  = 4'd8;
	localparam logic [3:0] ST_NSQ  = 4'd9;
	localparam logic [3:0] ST_NRT  = 4'd10;
	localparam logic [3:0] ST_DIV  = 4'd11;
	localparam logic [3:0] ST_TW   = 4'd12;
	localparam logic [3:0] ST_OUT  = 4'd13;
	localparam logic [3:0] ST_DLD  = 4'd14;

	function automatic logic [CW-1:0] satc(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] lo;
		hi = signed'((SW'(1) << (CW-1)) - SW'(1));
		lo = -hi - SW'(1);
		if (v > hi) begin
			satc = hi[CW-1:0];
		end else if (v < lo) begin
			satc = lo[CW-1:0];
		end else begin
			satc = v[CW-1:0];
		end
	endfunction

	logic [3:0] state_q;
	logic [4:0] cnt_q;
	logic [4:0] k_q;

	logic [SCALE_W-1:0] scale_q;

	logic signed [CW-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic signed [CW-1:0] pend_x_q, pend_y_q, pend_z_q;
	logic                 pend_mk_q;
	logic [1:0]           seen_q;
	nrm_t                 nrm_x_q, nrm_z_q;
	logic                 nv_q, tw_q;
	logic [TEX_W-1:0]     acc_q;

	logic signed [CW-1:0] in_x_q, in_y_q, in_z_q;
	logic                 in_last_q, in_mk_q, second_q;

	logic signed [CW-1:0] ep_x_q, ep_y_q, ep_z_q, eq_x_q, eq_z_q;
	logic                 elast_q;

	logic [MW-1:0] ma_q, mb_q, mc_q;
	logic [63:0]   sum_q, prod_q;
	logic [63:0]   sq_v_q, sq_r_q, sq_b_q;
	logic [32:0]   rem_q;
	logic [15:0]   dn_q, quo_q, qa_q;
	logic          dsel_q, skip_q, dxn_q, dzn_q;

	logic [OW-1:0] out_data_q;
	logic          out_tw_q, out_last_q;

	logic signed [CW-1:0] pt_x, pt_y, pt_z;
	logic                 pt_mk;
	assign pt_x  = s_tdata[CW-1:0];
	assign pt_y  = s_tdata[2*CW-1:CW];
	assign pt_z  = s_tdata[3*CW-1:2*CW];
	assign pt_mk = (pt_x == '0) && (pt_y == '0) && (pt_z == '0);

	// shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (state_q)
			ST_LSQ: begin
				case (cnt_q[1:0])
					2'd0:    mul_a = ma_q[31:0];
					2'd1:    mul_a = mb_q[31:0];
					default: mul_a = mc_q[31:0];
				endcase
				mul_b = mul_a;
			end
			ST_NSQ: begin
				mul_a = cnt_q[0] ? mb_q[31:0] : ma_q[31:0];
				mul_b = mul_a;
			end
			ST_STR: begin
				mul_a = sq_r_q[31:0];
				mul_b = 32'(scale_q);
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end
	assign mul_p = 64'(mul_a) * 64'(mul_b);
	logic [63:0] sum_nx;
	assign sum_nx = sum_q + mul_p;

	// differences against the previous centre
	logic signed [CW:0] dl_x, dl_y, dl_z, dn_x, dn_z;
	logic signed [CW:0] ab_x, ab_y, ab_z, an_x, an_z;
	assign dl_x = {ep_x_q[CW-1], ep_x_q} - {prev_x_q[CW-1], prev_x_q};
	assign dl_y = {ep_y_q[CW-1], ep_y_q} - {prev_y_q[CW-1], prev_y_q};
	assign dl_z = {ep_z_q[CW-1], ep_z_q} - {prev_z_q[CW-1], prev_z_q};
	assign dn_x = {eq_x_q[CW-1], eq_x_q} - {prev_x_q[CW-1], prev_x_q};
	assign dn_z = {eq_z_q[CW-1], eq_z_q} - {prev_z_q[CW-1], prev_z_q};
	assign ab_x = dl_x[CW] ? -dl_x : dl_x;
	assign ab_y = dl_y[CW] ? -dl_y : dl_y;
	assign ab_z = dl_z[CW] ? -dl_z : dl_z;
	assign an_x = dn_x[CW] ? -dn_x : dn_x;
	assign an_z = dn_z[CW] ? -dn_z : dn_z;

	logic big_a, big_b, big_c, low_ab;
	assign big_a  = |(ma_q >> 31);
	assign big_b  = |(mb_q >> 31);
	assign big_c  = |(mc_q >> 31);
	assign low_ab = (ma_q < (MW'(1) << 30)) && (mb_q < (MW'(1) << 30));

	// square root step
	logic [63:0] sq_rb;
	logic        sq_ge;
	assign sq_rb = sq_r_q + sq_b_q;
	assign sq_ge = sq_v_q >= sq_rb;

	// stretch increment
	logic [63:0] len_sh, str_inc, acc_sum;
	assign len_sh  = sq_r_q << k_q;
	assign str_inc = (len_sh > LEN_CAP) ? (64'(scale_q) << 33) : ((prod_q << k_q) >> 7);
	assign acc_sum = 64'(acc_q) + str_inc;

	// divider step and numerators
	logic [33:0] dv_t, dv_d;
	logic        dv_ge;
	logic [45:0] num_a, num_b;
	assign dv_t  = {rem_q, dn_q[15]};
	assign dv_d  = 34'(sq_r_q[31:0]);
	assign dv_ge = dv_t >= dv_d;
	assign num_a = (46'(ma_q[30:0]) << 14) + 46'(sq_r_q[31:1]);
	assign num_b = (46'(mb_q[30:0]) << 14) + 46'(sq_r_q[31:1]);
	logic [15:0] quo_nx;
	assign quo_nx = {quo_q[14:0], dv_ge};

	// normal, twist and vertices
	nrm_t nx_c, nz_c;
	logic signed [31:0] dot;
	logic               twn;
	logic signed [17:0] ox, oz, ox0, oz0;
	always_comb begin
		if (skip_q) begin
			nx_c = nrm_x_q;
			nz_c = nrm_z_q;
		end else begin
			nx_c = dzn_q ? signed'(quo_q) : -signed'(quo_q);
			nz_c = dxn_q ? -signed'(qa_q) : signed'(qa_q);
		end
	end
	assign dot = 32'(nx_c) * 32'(nrm_x_q) + 32'(nz_c) * 32'(nrm_z_q);
	assign twn = tw_q ^ (nv_q && (dot < 0));
	assign ox0 = {nx_c, 2'b00};
	assign oz0 = {nz_c, 2'b00};
	assign ox  = twn ? -ox0 : ox0;
	assign oz  = twn ? -oz0 : oz0;

	logic [CW-1:0] lx, lz, rx, rz;
	assign lx = satc(SW'(ep_x_q) + SW'(ox));
	assign lz = satc(SW'(ep_z_q) + SW'(oz));
	assign rx = satc(SW'(ep_x_q) - SW'(ox));
	assign rz = satc(SW'(ep_z_q) - SW'(oz));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			k_q        <= '0;
			scale_q    <= SCALE_RST;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			prev_z_q   <= '0;
			pend_x_q   <= '0;
			pend_y_q   <= '0;
			pend_z_q   <= '0;
			pend_mk_q  <= 1'b0;
			seen_q     <= 2'd0;
			nrm_x_q    <= '0;
			nrm_z_q    <= NRM_ONE;
			nv_q       <= 1'b0;
			tw_q       <= 1'b0;
			acc_q      <= '0;
			second_q   <= 1'b0;
			in_last_q  <= 1'b0;
			in_mk_q    <= 1'b0;
			elast_q    <= 1'b0;
			dsel_q     <= 1'b0;
			skip_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				scale_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						in_x_q    <= pt_x;
						in_y_q    <= pt_y;
						in_z_q    <= pt_z;
						in_last_q <= s_tlast;
						in_mk_q   <= pt_mk;
						if (seen_q == 2'd0) begin
							if (!s_tlast) begin
								nrm_x_q   <= '0;
								nrm_z_q   <= NRM_ONE;
								nv_q      <= 1'b0;
								tw_q      <= 1'b0;
								acc_q     <= '0;
								pend_x_q  <= pt_x;
								pend_y_q  <= pt_y;
								pend_z_q  <= pt_z;
								pend_mk_q <= pt_mk;
								seen_q    <= 2'd1;
							end
						end else begin
							second_q <= s_tlast && !pt_mk;
							elast_q  <= s_tlast && pt_mk;
							if (pend_mk_q) begin
								prev_x_q <= pt_x;
								prev_y_q <= pt_y;
								prev_z_q <= pt_z;
								tw_q     <= 1'b0;
								nv_q     <= 1'b0;
								ep_x_q   <= pt_x;
								ep_y_q   <= pt_y;
								ep_z_q   <= pt_z;
								eq_x_q   <= pt_x;
								eq_z_q   <= pt_z;
							end else begin
								if (seen_q == 2'd1) begin
									prev_x_q <= pend_x_q;
									prev_y_q <= pend_y_q;
									prev_z_q <= pend_z_q;
								end
								ep_x_q <= pend_x_q;
								ep_y_q <= pend_y_q;
								ep_z_q <= pend_z_q;
								eq_x_q <= pt_mk ? pend_x_q : pt_x;
								eq_z_q <= pt_mk ? pend_z_q : pt_z;
							end
							state_q <= ST_LD;
						end
					end
				end
				ST_LD: begin
					ma_q    <= MW'(ab_x[CW-1:0]);
					mb_q    <= MW'(ab_y[CW-1:0]);
					mc_q    <= MW'(ab_z[CW-1:0]);
					k_q     <= '0;
					state_q <= ST_LSH;
				end
				ST_LSH: begin
					if (big_a || big_b || big_c) begin
						ma_q <= ma_q >> 1;
						mb_q <= mb_q >> 1;
						mc_q <= mc_q >> 1;
						k_q  <= k_q + 5'd1;
					end else begin
						sum_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_LSQ;
					end
				end
				ST_LSQ: begin
					sum_q <= sum_nx;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd2) begin
						sq_v_q  <= sum_nx;
						sq_r_q  <= '0;
						sq_b_q  <= 64'd1 << 62;
						cnt_q   <= '0;
						state_q <= ST_LRT;
					end
				end
				ST_LRT, ST_NRT: begin
					if (sq_ge) begin
						sq_v_q <= sq_v_q - sq_rb;
						sq_r_q <= (sq_r_q >> 1) + sq_b_q;
					end else begin
						sq_r_q <= sq_r_q >> 1;
					end
					sq_b_q <= sq_b_q >> 2;
					cnt_q  <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						cnt_q   <= '0;
						state_q <= (state_q == ST_LRT) ? ST_STR : ST_DLD;
						dsel_q  <= 1'b0;
					end
				end
				ST_STR: begin
					prod_q  <= mul_p;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					acc_q   <= (acc_sum > 64'(STR_SAT)) ? STR_SAT : acc_sum[TEX_W-1:0];
					state_q <= ST_NLD;
				end
				ST_NLD: begin
					dxn_q <= dn_x[CW];
					dzn_q <= dn_z[CW];
					ma_q  <= MW'(an_x[CW-1:0]);
					mb_q  <= MW'(an_z[CW-1:0]);
					if (dn_x == '0 && dn_z == '0) begin
						skip_q  <= 1'b1;
						state_q <= ST_TW;
					end else begin
						skip_q  <= 1'b0;
						state_q <= ST_NSH;
					end
				end
				ST_NSH: begin
					if (big_a || big_b) begin
						ma_q <= ma_q >> 1;
						mb_q <= mb_q >> 1;
					end else if (low_ab) begin
						ma_q <= ma_q << 1;
						mb_q <= mb_q << 1;
					end else begin
						sum_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_NSQ;
					end
				end
				ST_NSQ: begin
					sum_q <= sum_nx;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd1) begin
						sq_v_q  <= sum_nx;
						sq_r_q  <= '0;
						sq_b_q  <= 64'd1 << 62;
						cnt_q   <= '0;
						state_q <= ST_NRT;
					end
				end
				ST_DLD: begin
					// load the first division once the root is complete
					rem_q   <= 33'(num_a >> 16);
					quo_q   <= '0;
					dn_q    <= num_a[15:0];
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q[4]) begin
						// load the next division, or go on to the twist after the second
						if (!dsel_q) begin
							qa_q   <= quo_q;
							rem_q  <= 33'(num_b >> 16);
							dn_q   <= num_b[15:0];
							quo_q  <= '0;
							dsel_q <= 1'b1;
							cnt_q  <= 5'd0;
						end else begin
							state_q <= ST_TW;
						end
					end else begin
						rem_q <= dv_ge ? 33'(dv_t - dv_d) : dv_t[32:0];
						quo_q <= quo_nx;
						dn_q  <= dn_q << 1;
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_TW: begin
					nrm_x_q    <= nx_c;
					nrm_z_q    <= nz_c;
					nv_q       <= 1'b1;
					tw_q       <= twn;
					prev_x_q   <= ep_x_q;
					prev_y_q   <= ep_y_q;
					prev_z_q   <= ep_z_q;
					out_data_q <= OW'({~acc_q + 32'd1, ep_z_q, ep_y_q, ep_x_q,
						rz, ep_y_q, rx, lz, ep_y_q, lx});
					out_tw_q   <= !twn;
					out_last_q <= elast_q;
					state_q    <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						if (second_q) begin
							second_q <= 1'b0;
							elast_q  <= 1'b1;
							ep_x_q   <= in_x_q;
							ep_y_q   <= in_y_q;
							ep_z_q   <= in_z_q;
							eq_x_q   <= in_x_q;
							eq_z_q   <= in_z_q;
							state_q  <= ST_LD;
						end else begin
							if (in_last_q) begin
								seen_q <= 2'd0;
							end else begin
								pend_x_q  <= in_x_q;
								pend_y_q  <= in_y_q;
								pend_z_q  <= in_z_q;
								pend_mk_q <= in_mk_q;
								seen_q    <= 2'd2;
							end
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_tw_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== hdl/pre_chk.sv =====
// Port checker for the polyline ribbon extruder, bound to its top level.
// Depends on pre_pkg for the coordinate width default.
module pre_chk
	import pre_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((9*COORD_WIDTH+32+7)/8)*8-1:0] m_tdata,
	input logic m_tuser,
	input logic m_tlast
);

	localparam int TB = 9*COORD_WIDTH;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("result item changed while stalled");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while a result item waits");

	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> !m_tvalid)
		else $error("result items back to back");

	a_tex: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[TB+31] || (m_tdata[TB+31:TB] == 32'd0)))
		else $error("tex_v above zero");

endmodule

bind polyline_ribbon_extruder pre_chk #(.COORD_WIDTH(COORD_WIDTH)) u_pre_chk (.*);
